/* hw/rtl/mss_pkg.sv */
package mss_pkg;

	localparam int MAX_SIDE_DEF = 512;
	localparam int MIN_SIDE     = 3;

	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int THR_W     = 4;
	localparam int COORD_W   = 9;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SET_AT_MOST    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_AT_LEAST = 2'd3;

	localparam logic [CFG_W-1:0] GRID_COLS_RST      = 10'd501;
	localparam logic [CFG_W-1:0] GRID_ROWS_RST      = 10'd501;
	localparam logic [THR_W-1:0] SET_AT_MOST_RST    = 4'd3;
	localparam logic [THR_W-1:0] CLEAR_AT_LEAST_RST = 4'd5;

	localparam logic [THR_W-1:0] NEIGHBORS = 4'd8;

	localparam logic OP_CELL = 1'b0;

endpackage

/* hw/rtl/mss_pixel_if.sv */
interface mss_pixel_if;
	logic valid;
	logic ready;
	logic op;
	logic cell_in;

	modport source (output valid, output op, output cell_in, input ready);
	modport sink (input valid, input op, input cell_in, output ready);
endinterface

/* hw/rtl/mss_result_if.sv */
interface mss_result_if;
	import mss_pkg::*;

	logic               valid;
	logic               ready;
	logic               cell_out;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic               frame_last;

	modport source (output valid, output cell_out, output out_row, output out_col,
		output frame_last, input ready);
	modport sink (input valid, input cell_out, input out_row, input out_col,
		input frame_last, output ready);
endinterface

/* hw/rtl/mss_ram.sv */
module mss_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

/* hw/rtl/majority_smoothing_3x3_in_place_top.sv */
// Streaming 3x3 majority smoothing, one in-place pass over a binary grid that arrives in
// raster order, one cell per transfer. A cell is emitted grid_cols + 1 cells behind the
// input; after the last input cell, flush transfers (op = 1) drain the tail, one cell
// each. The block takes one transfer per cycle unless the result side holds back a cell: each
// emitted cell costs one read of the two line buffers (original cells, two rows by parity;
// smoothed cells, one row) in the cycle of the transfer, and the count and threshold run in
// the next cycle, where the smoothed left neighbor feeds back from the cell just finished.
// A result passes the compute stage into the output register. A write to grid_cols or
// grid_rows restarts the frame; the user is to write configuration only while the block is
// idle, and the block does not enforce it. The line buffers get no clearing pass after reset.
module majority_smoothing_3x3_in_place_top #(
	parameter int MAX_SIDE = mss_pkg::MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mss_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [mss_pkg::CFG_W-1:0]     wr_data,
	mss_pixel_if.sink                     pixel,
	mss_result_if.source                  result
);

	import mss_pkg::*;

	localparam int AW         = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SW         = $clog2(MAX_SIDE + 1);
	localparam int CW         = (SW > CFG_W) ? SW : CFG_W;
	localparam int LINE_DEPTH = 2 ** AW;

	// configuration
	logic [CFG_W-1:0] cols_q;
	logic [CFG_W-1:0] rows_q;
	logic [THR_W-1:0] set_thr_q;
	logic [THR_W-1:0] clr_thr_q;
	logic [SW-1:0]    cols_c;
	logic [SW-1:0]    rows_c;

	// input and emit position
	logic [SW-1:0] in_row_q;
	logic [AW-1:0] in_col_q;
	logic [AW-1:0] er_q;
	logic [AW-1:0] ec_q;
	logic [2:0]    below_q;

	// accept stage
	logic          acc;
	logic          in_done;
	logic          is_wr;
	logic [SW-1:0] col_inc;
	logic          col_wrap;
	logic [SW-1:0] col_nx;
	logic [SW-1:0] row_nx;
	logic          emit;
	logic          fire0;
	logic          ec_last;
	logic          er_last;
	logic          last0;
	logic          interior0;
	logic [AW-1:0] ec_inc;
	logic [2:0]    below_nx;

	// compute stage
	logic          v_s1;
	logic [AW-1:0] er_s1;
	logic [AW-1:0] ec_s1;
	logic          last_s1;
	logic          int_s1;
	logic [2:0]    below_s1;
	logic          s1_fire;
	logic          left_q;
	logic          upl_q;
	logic [7:0]    nbr;
	logic [THR_W-1:0] setc;
	logic [THR_W-1:0] unset;
	logic          val;

	// line buffer read data
	logic old_rd_a;
	logic old_rd_b;
	logic new_rd_a;
	logic new_rd_b;

	// output register
	logic               ov_q;
	logic               cell_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic               last_q;

	always_comb begin
		logic [CW-1:0] wc;
		logic [CW-1:0] wr;
		wc = CW'(cols_q);
		wr = CW'(rows_q);
		if (wc < CW'(MIN_SIDE)) begin
			cols_c = SW'(MIN_SIDE);
		end else if (wc > CW'(MAX_SIDE)) begin
			cols_c = SW'(MAX_SIDE);
		end else begin
			cols_c = SW'(wc);
		end
		if (wr < CW'(MIN_SIDE)) begin
			rows_c = SW'(MIN_SIDE);
		end else if (wr > CW'(MAX_SIDE)) begin
			rows_c = SW'(MAX_SIDE);
		end else begin
			rows_c = SW'(wr);
		end
	end

	assign acc      = pixel.valid && pixel.ready;
	assign in_done  = in_row_q >= rows_c;
	assign is_wr    = (pixel.op == OP_CELL) && !in_done;
	assign col_inc  = SW'(in_col_q) + SW'(1);
	assign col_wrap = col_inc >= cols_c;
	assign col_nx   = col_wrap ? '0 : col_inc;
	assign row_nx   = col_wrap ? in_row_q + SW'(1) : in_row_q;
	// enough cells in hand once row 1 holds two cells past its start
	assign emit     = is_wr ? ((row_nx >= SW'(2)) || ((row_nx == SW'(1)) && (col_nx >= SW'(2))))
		: in_done;
	assign fire0    = acc && emit;

	assign ec_last   = SW'(ec_q) == cols_c - SW'(1);
	assign er_last   = SW'(er_q) == rows_c - SW'(1);
	assign last0     = ec_last && er_last;
	assign interior0 = (er_q != '0) && !er_last && (ec_q != '0) && !ec_last;
	assign ec_inc    = ec_q + AW'(1);
	// last three cells of the row below: right, center, left
	assign below_nx  = {below_q[1:0], pixel.cell_in};

	assign s1_fire     = v_s1 && (!ov_q || result.ready);
	assign pixel.ready = !v_s1 || s1_fire;

	mss_ram #(
		.WIDTH (1),
		.DEPTH (2 * LINE_DEPTH)
	) u_old_ram (
		.clk       (clk),
		.wr_en     (acc && is_wr),
		.wr_addr   ({in_row_q[0], in_col_q}),
		.wr_data   (pixel.cell_in),
		.rd_en     (fire0),
		.rd_addr_a ({er_q[0], ec_q}),
		.rd_addr_b ({er_q[0], ec_inc}),
		.rd_data_a (old_rd_a),
		.rd_data_b (old_rd_b)
	);

	mss_ram #(
		.WIDTH (1),
		.DEPTH (LINE_DEPTH)
	) u_new_ram (
		.clk       (clk),
		.wr_en     (s1_fire),
		.wr_addr   (ec_s1),
		.wr_data   (val),
		.rd_en     (fire0),
		.rd_addr_a (ec_inc),
		.rd_addr_b (ec_q),
		.rd_data_a (new_rd_a),
		.rd_data_b (new_rd_b)
	);

	assign nbr = {upl_q, new_rd_b, new_rd_a, left_q, old_rd_b, below_s1};

	always_comb begin
		setc = '0;
		for (int k = 0; k < 8; k++) begin
			setc = setc + THR_W'(nbr[k]);
		end
		unset = NEIGHBORS - setc;
		val   = old_rd_a;
		if (int_s1) begin
			if (unset <= set_thr_q) begin
				val = 1'b1;
			end
			if (unset >= clr_thr_q) begin
				val = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= GRID_COLS_RST;
			rows_q    <= GRID_ROWS_RST;
			set_thr_q <= SET_AT_MOST_RST;
			clr_thr_q <= CLEAR_AT_LEAST_RST;
			in_row_q  <= '0;
			in_col_q  <= '0;
			er_q      <= '0;
			ec_q      <= '0;
			v_s1      <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (acc && is_wr) begin
				in_col_q <= AW'(col_nx);
				in_row_q <= row_nx;
			end
			if (fire0) begin
				if (last0) begin
					// frame done: rewind for the next frame
					in_row_q <= '0;
					in_col_q <= '0;
					er_q     <= '0;
					ec_q     <= '0;
				end else if (ec_last) begin
					ec_q <= '0;
					er_q <= er_q + AW'(1);
				end else begin
					ec_q <= ec_inc;
				end
			end

			if (wr_en) begin
				case (wr_index)
					REG_GRID_COLS: begin
						cols_q   <= wr_data;
						in_row_q <= '0;
						in_col_q <= '0;
						er_q     <= '0;
						ec_q     <= '0;
					end
					REG_GRID_ROWS: begin
						rows_q   <= wr_data;
						in_row_q <= '0;
						in_col_q <= '0;
						er_q     <= '0;
						ec_q     <= '0;
					end
					REG_SET_AT_MOST:    set_thr_q <= wr_data[THR_W-1:0];
					REG_CLEAR_AT_LEAST: clr_thr_q <= wr_data[THR_W-1:0];
					default: ;
				endcase
			end

			if (fire0) begin
				v_s1 <= 1'b1;
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end

			if (s1_fire) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_wr) begin
			below_q <= below_nx;
		end
		if (fire0) begin
			er_s1    <= er_q;
			ec_s1    <= ec_q;
			last_s1  <= last0;
			int_s1   <= interior0;
			below_s1 <= is_wr ? below_nx : below_q;
		end
		if (s1_fire) begin
			left_q <= val;
			upl_q  <= new_rd_b;
			cell_q <= val;
			row_q  <= COORD_W'(er_s1);
			col_q  <= COORD_W'(ec_s1);
			last_q <= last_s1;
		end
	end

	assign result.valid      = ov_q;
	assign result.cell_out   = cell_q;
	assign result.out_row    = row_q;
	assign result.out_col    = col_q;
	assign result.frame_last = last_q;

	a_in_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= rows_c)
		else $error("input row count beyond grid");

	a_emit_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(ec_q) < cols_c)
		else $error("emit column beyond grid");

	a_frame_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(fire0 && last0) |=> (in_row_q == '0 && in_col_q == '0 && er_q == '0 && ec_q == '0))
		else $error("counters not rewound after last cell");

	// unused lanes may read entries never written, so compare X as a value
	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_fire) |=> (v_s1
			&& ({old_rd_a, old_rd_b, new_rd_a, new_rd_b}
				=== $past({old_rd_a, old_rd_b, new_rd_a, new_rd_b}))))
		else $error("line buffer data changed under a stalled cell");

endmodule
